FILE: rtl/mlfp_pkg.sv
// Shared types and constants of the magic/length frame parser.
package mlfp_pkg;

  // Header bytes ahead of the command: magic, length low, length high
  localparam int HDR_BYTES = 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PONG       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_DOWN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_MOVE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_UP   = 3'd6;

  // Event codes on the output
  typedef enum logic [3:0] {
    EV_PONG    = 4'd0,
    EV_KEY1    = 4'd1,
    EV_KEY2    = 4'd2,
    EV_TDOWN   = 4'd3,
    EV_TMOVE   = 4'd4,
    EV_TUP     = 4'd5,
    EV_TSHORT  = 4'd6,
    EV_UNKNOWN = 4'd7,
    EV_BADLEN  = 4'd8
  } event_e;

  // Configuration registers
  typedef struct packed {
    logic [7:0] magic;
    logic [7:0] pong;
    logic [7:0] key1;
    logic [7:0] key2;
    logic [7:0] touch_down;
    logic [7:0] touch_move;
    logic [7:0] touch_up;
  } cfg_t;

  // Frame descriptor handed from front to back
  typedef struct packed {
    logic            bad;   // bad length, len holds the declared length
    logic [7:0]      cmd;
    logic [15:0]     len;   // payload length, or declared length when bad
    logic [3:0][7:0] head;  // first four payload bytes, head[0] first
  } desc_t;

endpackage

FILE: rtl/magic_length_frame_parser.sv
// Top level of the magic-prefixed, length-prefixed frame parser.
//
//   Channel   Dir  Handshake                     Beat contents
//   s_axis    in   s_axis_tvalid_i/tready_o      one received byte
//   m_axis    out  m_axis_tvalid_o/tready_i      one frame or bad-length event
//   cfg       in   cfg_we_i                      register index, 8-bit value
//
// One byte is taken per cycle while the queue has space; the front tracks the frame.
// m_axis_tvalid_o rises after the descriptor passes the queue and the decode stage's
// output register: the edge that takes the last byte writes it into the queue, and
// a later edge, once the output register is free or being emptied, loads it there.
// s_axis stalls whenever the two-entry queue is full, i.e. once m_axis has
// held back three events (one in the output register, two queued). Reset
// restores all register defaults and returns the parser to hunting for the
// magic byte.
module magic_length_frame_parser #(
  parameter int MAX_FRAME = 256,
  parameter int TOUCH_LEN = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // data_byte
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // event_code[3:0], command[11:4], touch_x[27:12], touch_y[43:28],
  // payload_length[59:44], zero fill[63:60]
  output logic [63:0]                    m_axis_tdata_o,
  input  logic                           cfg_we_i,
  input  logic [mlfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i
);

  mlfp_pkg::cfg_t   cfg_q;
  mlfp_pkg::desc_t  push_desc, pop_desc;
  logic             push, space, q_valid, pop;
  mlfp_pkg::event_e ev;
  logic [7:0]       cmd;
  logic [15:0]      x, y, len;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic      <= 8'd170;
      cfg_q.pong       <= 8'd1;
      cfg_q.key1       <= 8'd2;
      cfg_q.key2       <= 8'd3;
      cfg_q.touch_down <= 8'd4;
      cfg_q.touch_move <= 8'd5;
      cfg_q.touch_up   <= 8'd6;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlfp_pkg::REG_MAGIC:      cfg_q.magic      <= cfg_wdata_i;
        mlfp_pkg::REG_PONG:       cfg_q.pong       <= cfg_wdata_i;
        mlfp_pkg::REG_KEY1:       cfg_q.key1       <= cfg_wdata_i;
        mlfp_pkg::REG_KEY2:       cfg_q.key2       <= cfg_wdata_i;
        mlfp_pkg::REG_TOUCH_DOWN: cfg_q.touch_down <= cfg_wdata_i;
        mlfp_pkg::REG_TOUCH_MOVE: cfg_q.touch_move <= cfg_wdata_i;
        mlfp_pkg::REG_TOUCH_UP:   cfg_q.touch_up   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mlfp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .magic_i      (cfg_q.magic),
    .space_i      (space),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  mlfp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .space_o     (space),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_desc)
  );

  mlfp_back #(.TOUCH_LEN(TOUCH_LEN)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .desc_valid_i (q_valid),
    .desc_i       (pop_desc),
    .pop_o        (pop),
    .ev_valid_o   (m_axis_tvalid_o),
    .ev_ready_i   (m_axis_tready_i),
    .ev_o         (ev),
    .cmd_o        (cmd),
    .x_o          (x),
    .y_o          (y),
    .len_o        (len)
  );

  assign m_axis_tdata_o = {4'b0000, len, y, x, cmd, ev};

endmodule

FILE: rtl/mlfp_front.sv
// Front end: hunts for the magic byte, tracks the frame and emits descriptors.
module mlfp_front #(
  parameter int MAX_FRAME = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  output logic               byte_ready_o,
  input  logic [7:0]         byte_i,
  input  logic [7:0]         magic_i,
  input  logic               space_i,
  output logic               push_o,
  output mlfp_pkg::desc_t    desc_o
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int TW = 18;

  logic [CW-1:0]   cnt_q, cnt_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [3:0][7:0] head_q, head_d;
  logic            fire;
  logic [15:0]     len_full;
  logic [TW-1:0]   total;
  logic [TW-1:0]   cnt_inc;

  assign byte_ready_o = space_i;
  assign fire         = byte_valid_i & space_i;
  assign len_full     = {byte_i, len_q[7:0]};
  assign total        = TW'(mlfp_pkg::HDR_BYTES) + TW'(len_q);
  assign cnt_inc      = TW'(cnt_q) + TW'(1);

  // Byte position tracking and frame completion
  always_comb begin
    cnt_d  = cnt_q;
    len_d  = len_q;
    cmd_d  = cmd_q;
    head_d = head_q;
    push_o = 1'b0;
    desc_o = '0;
    if (fire) begin
      if (cnt_q == '0) begin
        if (byte_i == magic_i) cnt_d = CW'(1);
      end else if (cnt_q == CW'(1)) begin
        len_d = {8'h00, byte_i};
        cnt_d = CW'(2);
      end else if (cnt_q == CW'(2)) begin
        len_d = len_full;
        if (len_full == '0 ||
            (TW'(len_full) + TW'(mlfp_pkg::HDR_BYTES)) > TW'(MAX_FRAME)) begin
          cnt_d       = '0;
          push_o      = 1'b1;
          desc_o.bad  = 1'b1;
          desc_o.len  = len_full;
        end else begin
          cnt_d = CW'(mlfp_pkg::HDR_BYTES);
        end
      end else begin
        if (cnt_q == CW'(mlfp_pkg::HDR_BYTES)) begin
          cmd_d = byte_i;
        end else if (cnt_q >= CW'(4) && cnt_q < CW'(8)) begin
          head_d[cnt_q[1:0]] = byte_i;
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_inc >= total) begin
          cnt_d       = '0;
          push_o      = 1'b1;
          desc_o.cmd  = cmd_d;
          desc_o.len  = len_q - 16'd1;
          desc_o.head = head_d;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      len_q <= '0;
      cmd_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      len_q <= len_d;
      cmd_q <= cmd_d;
    end
  end

  // Payload head bytes
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

  // Count never passes the largest frame
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_FRAME - 1))
    else $error("frame byte count out of range");

  // Inside a frame body the declared length is never zero
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= CW'(mlfp_pkg::HDR_BYTES)) |-> (len_q != '0))
    else $error("frame body with zero length");

endmodule

FILE: rtl/mlfp_fifo.sv
// Two-entry descriptor queue between front and back.
module mlfp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mlfp_pkg::desc_t push_data_i,
  output logic            space_o,
  output logic            valid_o,
  input  logic            pop_i,
  output mlfp_pkg::desc_t pop_data_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  mlfp_pkg::desc_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     count_q;
  logic            do_push, do_pop;

  assign space_o    = count_q < (PW+1)'(DEPTH);
  assign valid_o    = count_q != '0;
  assign do_push    = push_i & space_o;
  assign do_pop     = pop_i & valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
      count_q <= count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PW+1)'(DEPTH))
    else $error("descriptor queue overfilled");

endmodule

FILE: rtl/mlfp_back.sv
// Back end: decodes the command of a descriptor and holds the event beat.
module mlfp_back #(
  parameter int TOUCH_LEN = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlfp_pkg::cfg_t     cfg_i,
  input  logic               desc_valid_i,
  input  mlfp_pkg::desc_t    desc_i,
  output logic               pop_o,
  output logic               ev_valid_o,
  input  logic               ev_ready_i,
  output mlfp_pkg::event_e   ev_o,
  output logic [7:0]         cmd_o,
  output logic [15:0]        x_o,
  output logic [15:0]        y_o,
  output logic [15:0]        len_o
);

  logic               valid_q;
  mlfp_pkg::event_e   ev_q, ev_d;
  logic [7:0]         cmd_q, cmd_d;
  logic [15:0]        x_q, x_d, y_q, y_d, len_q;
  logic               load;

  assign load  = desc_valid_i & (~valid_q | ev_ready_i);
  assign pop_o = load;

  // Command decode, first match wins
  always_comb begin
    cmd_d = desc_i.cmd;
    x_d   = '0;
    y_d   = '0;
    if (desc_i.bad) begin
      ev_d  = mlfp_pkg::EV_BADLEN;
      cmd_d = '0;
    end else if (desc_i.cmd == cfg_i.pong) begin
      ev_d = mlfp_pkg::EV_PONG;
    end else if (desc_i.cmd == cfg_i.key1) begin
      ev_d = mlfp_pkg::EV_KEY1;
    end else if (desc_i.cmd == cfg_i.key2) begin
      ev_d = mlfp_pkg::EV_KEY2;
    end else if (desc_i.cmd == cfg_i.touch_down || desc_i.cmd == cfg_i.touch_move) begin
      if (desc_i.len >= 16'(TOUCH_LEN)) begin
        ev_d = (desc_i.cmd == cfg_i.touch_down) ? mlfp_pkg::EV_TDOWN : mlfp_pkg::EV_TMOVE;
        x_d  = {desc_i.head[0], desc_i.head[1]};
        y_d  = {desc_i.head[2], desc_i.head[3]};
      end else begin
        ev_d = mlfp_pkg::EV_TSHORT;
      end
    end else if (desc_i.cmd == cfg_i.touch_up) begin
      ev_d = mlfp_pkg::EV_TUP;
    end else begin
      ev_d = mlfp_pkg::EV_UNKNOWN;
    end
  end

  // Output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (ev_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Output beat payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q  <= ev_d;
      cmd_q <= cmd_d;
      x_q   <= x_d;
      y_q   <= y_d;
      len_q <= desc_i.len;
    end
  end

  assign ev_valid_o = valid_q;
  assign ev_o       = ev_q;
  assign cmd_o      = cmd_q;
  assign x_o        = x_q;
  assign y_o        = y_q;
  assign len_o      = len_q;

  // Coordinates only on full touch down or move
  a_coord_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ev_q != mlfp_pkg::EV_TDOWN && ev_q != mlfp_pkg::EV_TMOVE)
      |-> (x_q == '0 && y_q == '0))
    else $error("coordinates on an event without them");

  // Bad length carries no command
  a_bad_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ev_q == mlfp_pkg::EV_BADLEN) |-> (cmd_q == '0))
    else $error("bad length event with a command");

endmodule

FILE: bench/frame_event_checker.sv
// Event checker for the frame parser: tracks the byte stream and compares every output beat.
`timescale 1ns / 100ps

module frame_event_checker #(
  parameter int MAX_FRAME = 256,
  parameter int TOUCH_LEN = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [7:0]                     s_axis_tdata_i,   // data_byte
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  // event_code[3:0], command[11:4], touch_x[27:12], touch_y[43:28],
  // payload_length[59:44], zero fill[63:60]
  input  logic [63:0]                    m_axis_tdata_i,
  input  logic                           cfg_we_i,
  input  logic [mlfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i,
  output int                             errors_o,
  output int                             pending_o
);

  // One predicted event beat
  typedef struct packed {
    mlfp_pkg::event_e ev;
    logic [7:0]       cmd;
    logic [15:0]      x;
    logic [15:0]      y;
    logic [15:0]      len;
  } frame_event_t;

  frame_event_t   expected_events[$];
  mlfp_pkg::cfg_t cfg_shadow;
  int             byte_pos;      // 0 = hunting for magic
  logic [15:0]    frame_len;
  logic [7:0]     frame_cmd;
  logic [7:0]     head_bytes[4];
  int             mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Register write, index seven and up is ignored
  task automatic apply_cfg(input logic [mlfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    case (idx)
      mlfp_pkg::REG_MAGIC:      cfg_shadow.magic = val;
      mlfp_pkg::REG_PONG:       cfg_shadow.pong = val;
      mlfp_pkg::REG_KEY1:       cfg_shadow.key1 = val;
      mlfp_pkg::REG_KEY2:       cfg_shadow.key2 = val;
      mlfp_pkg::REG_TOUCH_DOWN: cfg_shadow.touch_down = val;
      mlfp_pkg::REG_TOUCH_MOVE: cfg_shadow.touch_move = val;
      mlfp_pkg::REG_TOUCH_UP:   cfg_shadow.touch_up = val;
      default: ;
    endcase
  endtask

  // Classify a completed frame; first matching code wins
  function automatic frame_event_t decode_frame();
    frame_event_t e;
    logic [15:0]  plen;
    plen = frame_len - 16'd1;
    e = '0;
    e.cmd = frame_cmd;
    e.len = plen;
    if (frame_cmd == cfg_shadow.pong) begin
      e.ev = mlfp_pkg::EV_PONG;
    end else if (frame_cmd == cfg_shadow.key1) begin
      e.ev = mlfp_pkg::EV_KEY1;
    end else if (frame_cmd == cfg_shadow.key2) begin
      e.ev = mlfp_pkg::EV_KEY2;
    end else if (frame_cmd == cfg_shadow.touch_down ||
                 frame_cmd == cfg_shadow.touch_move) begin
      if (int'(plen) >= TOUCH_LEN) begin
        e.ev = (frame_cmd == cfg_shadow.touch_down) ? mlfp_pkg::EV_TDOWN
                                                    : mlfp_pkg::EV_TMOVE;
        e.x = {head_bytes[0], head_bytes[1]};
        e.y = {head_bytes[2], head_bytes[3]};
      end else begin
        e.ev = mlfp_pkg::EV_TSHORT;
      end
    end else if (frame_cmd == cfg_shadow.touch_up) begin
      e.ev = mlfp_pkg::EV_TUP;
    end else begin
      e.ev = mlfp_pkg::EV_UNKNOWN;
    end
    return e;
  endfunction

  // Advance the frame tracker by one accepted byte
  task automatic track_byte(input logic [7:0] b);
    frame_event_t e;
    if (byte_pos == 0) begin
      if (b == cfg_shadow.magic) byte_pos = 1;
    end else if (byte_pos == 1) begin
      frame_len = {8'h00, b};
      byte_pos = 2;
    end else if (byte_pos == 2) begin
      frame_len[15:8] = b;
      // bad length: the high length byte is consumed, not rescanned
      if (frame_len == 16'd0 || mlfp_pkg::HDR_BYTES + int'(frame_len) > MAX_FRAME) begin
        e = '0;
        e.ev = mlfp_pkg::EV_BADLEN;
        e.len = frame_len;
        expected_events.push_back(e);
        byte_pos = 0;
      end else begin
        byte_pos = 3;
      end
    end else begin
      if (byte_pos == 3) begin
        frame_cmd = b;
      end else if (byte_pos < 8) begin
        head_bytes[byte_pos-4] = b;
      end
      byte_pos++;
      if (byte_pos >= mlfp_pkg::HDR_BYTES + int'(frame_len)) begin
        byte_pos = 0;
        expected_events.push_back(decode_frame());
      end
    end
  endtask

  // Compare one output beat with the oldest prediction
  task automatic check_event(input logic [63:0] beat);
    frame_event_t e;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("event beat %h with no event expected", beat));
    end else begin
      e = expected_events.pop_front();
      if (beat[3:0] !== e.ev)
        report_mismatch($sformatf("event_code %0d, expected %0d (%s)",
                                  beat[3:0], e.ev, e.ev.name()));
      if (beat[11:4] !== e.cmd)
        report_mismatch($sformatf("command %h, expected %h", beat[11:4], e.cmd));
      if (beat[27:12] !== e.x)
        report_mismatch($sformatf("touch_x %h, expected %h", beat[27:12], e.x));
      if (beat[43:28] !== e.y)
        report_mismatch($sformatf("touch_y %h, expected %h", beat[43:28], e.y));
      if (beat[59:44] !== e.len)
        report_mismatch($sformatf("payload_length %h, expected %h", beat[59:44], e.len));
      if (beat[63:60] !== 4'h0)
        report_mismatch($sformatf("fill bits %h, expected 0", beat[63:60]));
    end
  endtask

  // Watch all three channels; an output beat is checked before the byte taken on the same edge is tracked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_shadow = '{magic: 8'd170, pong: 8'd1, key1: 8'd2, key2: 8'd3,
                     touch_down: 8'd4, touch_move: 8'd5, touch_up: 8'd6};
      byte_pos = 0;
      frame_len = '0;
      frame_cmd = '0;
      expected_events.delete();
      mismatches = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) apply_cfg(cfg_idx_i, cfg_wdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_event(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i) track_byte(s_axis_tdata_i);
      errors_o <= mismatches;
      pending_o <= expected_events.size();
    end
  end

endmodule

FILE: bench/magic_length_frame_parser_test.sv
// Testbench top for the frame parser: stimulus, back pressure and the final verdict.
`timescale 1ns / 100ps

module magic_length_frame_parser_test;

  localparam int MAX_FRAME = 256;
  localparam int TOUCH_LEN = 5;
  localparam logic [mlfp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [7:0]                     s_axis_tdata_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [63:0]                    m_axis_tdata_o;
  logic                           cfg_we_i;
  logic [mlfp_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]                     cfg_wdata_i;

  int         errors;
  int         pending;
  int         bytes_sent;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_cycles = 0;
  int         hold_left = 0;
  logic       hold_taken = 1'b0;
  logic [7:0] code_of[8];  // our copy of the registers, by index

  always #5 clk_i = ~clk_i;

  magic_length_frame_parser #(
    .MAX_FRAME(MAX_FRAME),
    .TOUCH_LEN(TOUCH_LEN)
  ) uut (.*);

  frame_event_checker #(
    .MAX_FRAME(MAX_FRAME),
    .TOUCH_LEN(TOUCH_LEN)
  ) event_check (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .errors_o(errors),
    .pending_o(pending)
  );

  // Receiver: random stalls, or one long hold-off once requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0 && !hold_taken) begin
      hold_left = hold_cycles;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // One byte beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Header, then command and payload if the length is legal; head goes first in payload
  task automatic send_frame(input logic [7:0] cmd, input int len, input logic [31:0] head);
    int i;
    send_byte(code_of[mlfp_pkg::REG_MAGIC]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len != 0 && mlfp_pkg::HDR_BYTES + len <= MAX_FRAME) begin
      send_byte(cmd);
      for (i = 1; i < len; i++) begin
        send_byte(i <= 4 ? head[(4-i)*8 +: 8] : 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [mlfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    code_of[idx] = val;
    @(posedge clk_i);
  endtask

  // Stop sending and wait for every expected event, plus the pipeline depth
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed frames, some bad lengths, truncated headers and noise
  task automatic random_traffic(input int budget);
    int         start;
    int         r;
    int         len;
    logic [7:0] cmd;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else if (r < 18) begin
        len = ($urandom_range(0, 3) == 0) ? 0
            : $urandom_range(MAX_FRAME - mlfp_pkg::HDR_BYTES + 1, 65535);
        send_frame(8'h00, len, 32'h0);
      end else if (r < 23) begin
        send_byte(code_of[mlfp_pkg::REG_MAGIC]);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      end else begin
        r = $urandom_range(0, 8);
        cmd = (r < 7) ? code_of[r] : 8'($urandom);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
        send_frame(cmd, len, $urandom);
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    bytes_sent = 0;
    send_idle_pct = 11;
    recv_idle_pct = 59;
    code_of = '{8'd170, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: noise, each event kind but a full touch move, touch length boundary, bad lengths
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(code_of[mlfp_pkg::REG_PONG], 1, 32'h0);
    send_frame(code_of[mlfp_pkg::REG_KEY1], 1, 32'h0);
    send_frame(code_of[mlfp_pkg::REG_KEY2], 2, 32'h0);
    send_frame(code_of[mlfp_pkg::REG_TOUCH_UP], 1, 32'h0);
    send_frame(8'hEE, 1, 32'h0);
    send_frame(code_of[mlfp_pkg::REG_TOUCH_DOWN], 6, 32'h8000_7FFF);
    send_frame(code_of[mlfp_pkg::REG_TOUCH_MOVE], 5, 32'h1234_5678);
    send_frame(8'h00, 0, 32'h0);
    send_frame(8'h00, 65535, 32'h0);
    // high length byte equals the magic and must not restart a frame
    send_frame(8'h00, {code_of[mlfp_pkg::REG_MAGIC], 8'h01}, 32'h0);
    random_traffic(45);
    drain();

    // Extreme and overlapping codes, plus an ignored register index
    write_reg(mlfp_pkg::REG_MAGIC, 8'h00);
    write_reg(mlfp_pkg::REG_PONG, 8'h55);
    write_reg(mlfp_pkg::REG_KEY1, 8'h55);
    write_reg(mlfp_pkg::REG_KEY2, 8'hFF);
    write_reg(mlfp_pkg::REG_TOUCH_DOWN, 8'h00);
    write_reg(mlfp_pkg::REG_TOUCH_MOVE, 8'h80);
    write_reg(mlfp_pkg::REG_TOUCH_UP, 8'h7F);
    write_reg(REG_UNUSED, 8'h33);
    cfg_we_i <= 1'b0;
    send_idle_pct = 59;
    recv_idle_pct = 11;
    random_traffic(45);
    drain();

    // Magic at the top, touch down and move sharing a code
    write_reg(mlfp_pkg::REG_MAGIC, 8'hFF);
    write_reg(mlfp_pkg::REG_PONG, 8'h10);
    write_reg(mlfp_pkg::REG_KEY1, 8'($urandom));
    write_reg(mlfp_pkg::REG_KEY2, 8'($urandom));
    write_reg(mlfp_pkg::REG_TOUCH_DOWN, 8'h42);
    write_reg(mlfp_pkg::REG_TOUCH_MOVE, 8'h42);
    write_reg(mlfp_pkg::REG_TOUCH_UP, 8'($urandom));
    cfg_we_i <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // receiver holds off while short frames keep coming, so input stalls
    hold_cycles = 40;
    repeat (6) send_frame(code_of[mlfp_pkg::REG_PONG], 1, 32'h0);
    // largest legal frame
    send_frame(code_of[mlfp_pkg::REG_TOUCH_DOWN], MAX_FRAME - mlfp_pkg::HDR_BYTES, $urandom);
    random_traffic(20);

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    repeat (5000) begin
      if (pending != 0) @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mlfp_pkg.sv
rtl/mlfp_front.sv
rtl/mlfp_fifo.sv
rtl/mlfp_back.sv
rtl/magic_length_frame_parser.sv
bench/frame_event_checker.sv
bench/magic_length_frame_parser_test.sv
